@@ rtl/core/sfck_pkg.sv @@
// Shared widths and the per-stage control bundle of the space-filling-curve key unit.
package sfck_pkg;

    localparam int COORD_W = 21;
    localparam int KEY_W   = 63;

    typedef enum logic
    {
        CURVE_MORTON  = 1'b0,
        CURVE_HILBERT = 1'b1
    } curve_t;

    typedef struct packed
    {
        logic   valid;
        curve_t curve;
    } stage_ctl_t;

endpackage

@@ rtl/core/sfck_cell.sv @@
// One Hilbert level cell: conditional inversions and swaps for a single bit level; Morton items pass unchanged.
module sfck_cell #(
    parameter int AXIS_BITS = 21,
    parameter int LEVEL     = 20
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfck_pkg::stage_ctl_t   ctl_in,
    input  logic [AXIS_BITS-1:0]   a0_in,
    input  logic [AXIS_BITS-1:0]   a1_in,
    input  logic [AXIS_BITS-1:0]   a2_in,
    output sfck_pkg::stage_ctl_t   ctl_out,
    output logic [AXIS_BITS-1:0]   a0_out,
    output logic [AXIS_BITS-1:0]   a1_out,
    output logic [AXIS_BITS-1:0]   a2_out
);

    localparam logic [AXIS_BITS-1:0] LOW = AXIS_BITS'((64'd1 << LEVEL) - 64'd1);

    sfck_pkg::stage_ctl_t ctl_reg;
    logic [AXIS_BITS-1:0] a0_reg;
    logic [AXIS_BITS-1:0] a1_reg;
    logic [AXIS_BITS-1:0] a2_reg;
    logic [AXIS_BITS-1:0] a0_next;
    logic [AXIS_BITS-1:0] a1_next;
    logic [AXIS_BITS-1:0] a2_next;

    always_comb
    begin
        logic [AXIS_BITS-1:0] sw;
        a0_next = a0_in;
        a1_next = a1_in;
        a2_next = a2_in;
        sw      = '0;
        if (ctl_in.curve == sfck_pkg::CURVE_HILBERT)
        begin
            // The x axis against itself can only invert, never swap.
            if (a0_next[LEVEL])
            begin
                a0_next = a0_next ^ LOW;
            end
            if (a1_next[LEVEL])
            begin
                a0_next = a0_next ^ LOW;
            end
            else
            begin
                sw      = (a0_next ^ a1_next) & LOW;
                a0_next = a0_next ^ sw;
                a1_next = a1_next ^ sw;
            end
            if (a2_next[LEVEL])
            begin
                a0_next = a0_next ^ LOW;
            end
            else
            begin
                sw      = (a0_next ^ a2_next) & LOW;
                a0_next = a0_next ^ sw;
                a2_next = a2_next ^ sw;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg <= a0_next;
        a1_reg <= a1_next;
        a2_reg <= a2_next;
    end

    assign ctl_out = ctl_reg;
    assign a0_out  = a0_reg;
    assign a1_out  = a1_reg;
    assign a2_out  = a2_reg;

endmodule

@@ rtl/core/sfck_out.sv @@
// Output stage: Gray decode, final correction and bit interleave into the key register; Morton keys only interleave.
module sfck_out #(
    parameter int AXIS_BITS = 21
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfck_pkg::stage_ctl_t          ctl_in,
    input  logic [AXIS_BITS-1:0]          a0_in,
    input  logic [AXIS_BITS-1:0]          a1_in,
    input  logic [AXIS_BITS-1:0]          a2_in,
    output logic                          done,
    output logic [sfck_pkg::KEY_W-1:0]    curve_key
);

    logic                       done_reg;
    logic [sfck_pkg::KEY_W-1:0] key_reg;
    logic [sfck_pkg::KEY_W-1:0] key_next;

    always_comb
    begin
        logic [AXIS_BITS-1:0] b0;
        logic [AXIS_BITS-1:0] b1;
        logic [AXIS_BITS-1:0] b2;
        logic [AXIS_BITS-1:0] fix;
        b1  = a1_in ^ a0_in;
        b2  = b1 ^ a2_in;
        fix = '0;
        // Bit j of the correction is the parity of all levels above j.
        for (int j = 0; j < AXIS_BITS; j++)
        begin
            for (int i = 0; i < AXIS_BITS; i++)
            begin
                if (i > j)
                begin
                    fix[j] = fix[j] ^ b2[i];
                end
            end
        end
        b0 = a0_in ^ fix;
        b1 = b1 ^ fix;
        b2 = b2 ^ fix;
        key_next = '0;
        for (int k = 0; k < AXIS_BITS; k++)
        begin
            if (ctl_in.curve == sfck_pkg::CURVE_HILBERT)
            begin
                key_next[3*k+2] = b0[k];
                key_next[3*k+1] = b1[k];
                key_next[3*k]   = b2[k];
            end
            else
            begin
                key_next[3*k]   = a0_in[k];
                key_next[3*k+1] = a1_in[k];
                key_next[3*k+2] = a2_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign done      = done_reg;
    assign curve_key = key_reg;

endmodule

@@ rtl/core/sfc_key_morton_hilbert_3d_top.sv @@
// Top level of the Morton / Hilbert 3D curve key unit: mode register, cell chain, output stage.
// Start reaches done through the chain of registered Hilbert level cells
// (AXIS_BITS-1 cells) and then the output register.
// Throughput: one item per cycle; busy is always low and every cell hands its item on each cycle.
// Reset (rst_n low, asynchronous) clears the valid flags in flight and selects the Morton key.
// The receiver cannot stall: each key shows on curve_key for exactly the one cycle done is high.
module sfc_key_morton_hilbert_3d_top #(
    parameter int AXIS_BITS = 21
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            start,
    output logic                            busy,
    input  logic [sfck_pkg::COORD_W-1:0]    coord_x,
    input  logic [sfck_pkg::COORD_W-1:0]    coord_y,
    input  logic [sfck_pkg::COORD_W-1:0]    coord_z,
    output logic                            done,
    output logic [sfck_pkg::KEY_W-1:0]      curve_key
);

    sfck_pkg::curve_t     curve_select_reg;
    sfck_pkg::stage_ctl_t stage_ctl [AXIS_BITS];
    logic [AXIS_BITS-1:0] stage_a0  [AXIS_BITS];
    logic [AXIS_BITS-1:0] stage_a1  [AXIS_BITS];
    logic [AXIS_BITS-1:0] stage_a2  [AXIS_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_select_reg <= sfck_pkg::CURVE_MORTON;
        end
        else if (cfg_we)
        begin
            curve_select_reg <= sfck_pkg::curve_t'(cfg_wdata);
        end
    end

    assign busy = 1'b0;

    assign stage_ctl[0].valid = start;
    assign stage_ctl[0].curve = curve_select_reg;
    assign stage_a0[0]        = coord_x[AXIS_BITS-1:0];
    assign stage_a1[0]        = coord_y[AXIS_BITS-1:0];
    assign stage_a2[0]        = coord_z[AXIS_BITS-1:0];

    // Cell k works on bit level AXIS_BITS-1-k, top level first.
    for (genvar k = 0; k < AXIS_BITS - 1; k++)
    begin : g_cell
        sfck_cell #(
            .AXIS_BITS (AXIS_BITS),
            .LEVEL     (AXIS_BITS - 1 - k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl_in  (stage_ctl[k]),
            .a0_in   (stage_a0[k]),
            .a1_in   (stage_a1[k]),
            .a2_in   (stage_a2[k]),
            .ctl_out (stage_ctl[k+1]),
            .a0_out  (stage_a0[k+1]),
            .a1_out  (stage_a1[k+1]),
            .a2_out  (stage_a2[k+1])
        );
    end

    sfck_out #(
        .AXIS_BITS (AXIS_BITS)
    ) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (stage_ctl[AXIS_BITS-1]),
        .a0_in     (stage_a0[AXIS_BITS-1]),
        .a1_in     (stage_a1[AXIS_BITS-1]),
        .a2_in     (stage_a2[AXIS_BITS-1]),
        .done      (done),
        .curve_key (curve_key)
    );

endmodule

@@ rtl/core/sfck_checker.sv @@
// Port-level checker for the curve key unit and its bind to the top level.
module sfck_checker #(
    parameter int AXIS_BITS = 21
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [sfck_pkg::KEY_W-1:0]   curve_key
);

    localparam int LAT = AXIS_BITS;

    // Every item taken comes out on done, at the delay that LAT sets.
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && rst_n) |-> ##LAT done)
        else $error("item accepted without a key LAT cycles later");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && rst_n, LAT))
        else $error("key delivered without a matching item");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((curve_key >> (3 * AXIS_BITS)) == '0))
        else $error("key has bits above three times the axis width");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(done) |-> !busy)
        else $error("busy raised while keys stream out");

endmodule

bind sfc_key_morton_hilbert_3d_top sfck_checker #(
    .AXIS_BITS (AXIS_BITS)
) u_sfck_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .curve_key (curve_key)
);
